// ----- design/bsa_pkg.sv -----
package bsa_pkg;

  // Header layout of a 24-bit bitmap file.
  localparam int unsigned HeaderBytes = 54;
  localparam logic [7:0] SigFirst = 8'h42;  // 'B'
  localparam logic [7:0] SigSecond = 8'h4D;  // 'M'
  localparam logic [5:0] HdrSigFirstIdx = 6'd0;
  localparam logic [5:0] HdrSigSecondIdx = 6'd1;
  localparam logic [5:0] HdrWidth0Idx = 6'd18;
  localparam logic [5:0] HdrWidth1Idx = 6'd19;
  localparam logic [5:0] HdrWidth2Idx = 6'd20;
  localparam logic [5:0] HdrWidth3Idx = 6'd21;
  localparam logic [5:0] HdrHeight0Idx = 6'd22;
  localparam logic [5:0] HdrHeight1Idx = 6'd23;
  localparam logic [5:0] HdrHeight2Idx = 6'd24;
  localparam logic [5:0] HdrHeight3Idx = 6'd25;
  localparam logic [5:0] HdrLastIdx = 6'(HeaderBytes - 1);

  localparam int unsigned RampLen = 70;
  localparam logic [6:0] RampMaxIdx = 7'(RampLen - 1);

  // Brightness ramp, darkest first.
  localparam logic [6:0] RampChars [RampLen] = '{
    7'h20, 7'h2E, 7'h27, 7'h60, 7'h5E, 7'h22, 7'h2C, 7'h3A, 7'h3B, 7'h49,
    7'h6C, 7'h21, 7'h69, 7'h3E, 7'h3C, 7'h7E, 7'h2B, 7'h5F, 7'h2D, 7'h3F,
    7'h5D, 7'h5B, 7'h7D, 7'h7B, 7'h31, 7'h29, 7'h28, 7'h7C, 7'h5C, 7'h2F,
    7'h74, 7'h66, 7'h6A, 7'h72, 7'h78, 7'h6E, 7'h75, 7'h76, 7'h63, 7'h7A,
    7'h58, 7'h59, 7'h55, 7'h4A, 7'h43, 7'h4C, 7'h51, 7'h30, 7'h4F, 7'h5A,
    7'h6D, 7'h77, 7'h71, 7'h70, 7'h64, 7'h62, 7'h6B, 7'h68, 7'h61, 7'h6F,
    7'h2A, 7'h23, 7'h4D, 7'h57, 7'h26, 7'h38, 7'h25, 7'h42, 7'h40, 7'h24
  };

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW = $clog2(FifoDepth);

  typedef enum logic [1:0] {
    StPixel    = 2'd0,
    StBadSig   = 2'd1,
    StOversize = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    PhHeader = 4'b0001,
    PhPixel  = 4'b0010,
    PhPad    = 4'b0100,
    PhDone   = 4'b1000
  } phase_e;

  // Classified item passed from the parser to the character mapper.
  typedef struct packed {
    logic [9:0]  sum;
    logic [11:0] x;
    logic [11:0] y;
    logic        last;
    status_e     status;
  } item_t;

endpackage

// ----- design/bsa_front.sv -----
module bsa_front #(
  parameter int unsigned MAX_WIDTH = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    data_byte_i,
  input  logic          file_start_i,
  output logic          push_o,
  output bsa_pkg::item_t item_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned XW = (CW > 12) ? CW : 12;
  localparam int unsigned YW = (RW > 12) ? RW : 12;

  bsa_pkg::phase_e phase_q, phase_d, phase_c;
  logic [5:0]    hdr_q, hdr_d, hdr_c;
  logic [31:0]   width_q, width_d, width_c;
  logic [31:0]   height_q, height_d, height_c;
  logic [CW-1:0] col_q, col_d, col_c, col_inc;
  logic [RW-1:0] row_q, row_d, row_c, row_inc;
  logic [1:0]    bip_q, bip_d, bip_c;
  logic [1:0]    pad_q, pad_d, pad_c, pad_dec;
  logic [7:0]    blue_q, blue_d;
  logic [7:0]    green_q, green_d;
  logic [XW-1:0] x_ext;
  logic [YW-1:0] y_ext;

  // A file start byte is parsed from a clean state.
  always_comb begin
    if (file_start_i) begin
      phase_c  = bsa_pkg::PhHeader;
      hdr_c    = '0;
      width_c  = '0;
      height_c = '0;
      col_c    = '0;
      row_c    = '0;
      bip_c    = '0;
      pad_c    = '0;
    end else begin
      phase_c  = phase_q;
      hdr_c    = hdr_q;
      width_c  = width_q;
      height_c = height_q;
      col_c    = col_q;
      row_c    = row_q;
      bip_c    = bip_q;
      pad_c    = pad_q;
    end
  end

  assign col_inc = col_c + CW'(1);
  assign row_inc = row_c + RW'(1);
  assign pad_dec = (pad_c != 2'd0) ? pad_c - 2'd1 : 2'd0;
  assign x_ext   = XW'(col_c);
  assign y_ext   = YW'(row_c);

  always_comb begin
    phase_d  = phase_c;
    hdr_d    = hdr_c;
    width_d  = width_c;
    height_d = height_c;
    col_d    = col_c;
    row_d    = row_c;
    bip_d    = bip_c;
    pad_d    = pad_c;
    blue_d   = blue_q;
    green_d  = green_q;
    push_o   = 1'b0;
    item_o   = '{sum: '0, x: '0, y: '0, last: 1'b0, status: bsa_pkg::StPixel};

    unique case (phase_c)
      bsa_pkg::PhHeader: begin
        hdr_d = hdr_c + 6'd1;
        if ((hdr_c == bsa_pkg::HdrSigFirstIdx && data_byte_i != bsa_pkg::SigFirst) ||
            (hdr_c == bsa_pkg::HdrSigSecondIdx && data_byte_i != bsa_pkg::SigSecond)) begin
          phase_d       = bsa_pkg::PhDone;
          push_o        = 1'b1;
          item_o.status = bsa_pkg::StBadSig;
        end else begin
          unique case (hdr_c)
            bsa_pkg::HdrWidth0Idx:  width_d[7:0]    = data_byte_i;
            bsa_pkg::HdrWidth1Idx:  width_d[15:8]   = data_byte_i;
            bsa_pkg::HdrWidth2Idx:  width_d[23:16]  = data_byte_i;
            bsa_pkg::HdrWidth3Idx:  width_d[31:24]  = data_byte_i;
            bsa_pkg::HdrHeight0Idx: height_d[7:0]   = data_byte_i;
            bsa_pkg::HdrHeight1Idx: height_d[15:8]  = data_byte_i;
            bsa_pkg::HdrHeight2Idx: height_d[23:16] = data_byte_i;
            bsa_pkg::HdrHeight3Idx: height_d[31:24] = data_byte_i;
            default: ;
          endcase
          if (hdr_c == bsa_pkg::HdrLastIdx) begin
            if (width_c > 32'(MAX_WIDTH) || height_c > 32'(MAX_HEIGHT)) begin
              phase_d       = bsa_pkg::PhDone;
              push_o        = 1'b1;
              item_o.status = bsa_pkg::StOversize;
            end else if (width_c == 32'd0 || height_c == 32'd0) begin
              phase_d = bsa_pkg::PhDone;
            end else begin
              phase_d = bsa_pkg::PhPixel;
            end
          end
        end
      end
      bsa_pkg::PhPixel: begin
        unique case (bip_c)
          2'd0: begin
            blue_d = data_byte_i;
            bip_d  = 2'd1;
          end
          2'd1: begin
            green_d = data_byte_i;
            bip_d   = 2'd2;
          end
          default: begin
            bip_d      = 2'd0;
            push_o     = 1'b1;
            item_o.sum = 10'(data_byte_i) + 10'(green_q) + 10'(blue_q);
            item_o.x   = x_ext[11:0];
            item_o.y   = y_ext[11:0];
            // The dimension check bounds width and height below 2**CW and 2**RW.
            if (col_inc == width_c[CW-1:0]) begin
              col_d = '0;
              row_d = row_inc;
              if (row_inc == height_c[RW-1:0]) begin
                item_o.last = 1'b1;
                phase_d     = bsa_pkg::PhDone;
              end else begin
                pad_d   = width_c[1:0];
                phase_d = (width_c[1:0] != 2'd0) ? bsa_pkg::PhPad : bsa_pkg::PhPixel;
              end
            end else begin
              col_d = col_inc;
            end
          end
        endcase
      end
      bsa_pkg::PhPad: begin
        pad_d = pad_dec;
        if (pad_dec == 2'd0) begin
          phase_d = bsa_pkg::PhPixel;
        end
      end
      bsa_pkg::PhDone: ;
      default: phase_d = bsa_pkg::PhDone;
    endcase

    if (!accept_i) begin
      push_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= bsa_pkg::PhHeader;
      hdr_q    <= '0;
      width_q  <= '0;
      height_q <= '0;
      col_q    <= '0;
      row_q    <= '0;
      bip_q    <= '0;
      pad_q    <= '0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      hdr_q    <= hdr_d;
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
      bip_q    <= bip_d;
      pad_q    <= pad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      blue_q  <= blue_d;
      green_q <= green_d;
    end
  end

endmodule

// ----- design/bsa_fifo.sv -----
module bsa_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bsa_pkg::item_t push_item_i,
  output logic           full_o,
  input  logic           pop_i,
  output bsa_pkg::item_t pop_item_o,
  output logic           empty_o
);

  localparam int unsigned PW = bsa_pkg::FifoPtrW;

  bsa_pkg::item_t mem_q [bsa_pkg::FifoDepth];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]   cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o     = (cnt_q == (PW + 1)'(bsa_pkg::FifoDepth));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_item_o = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + PW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + PW'(1) : rd_q;
    cnt_d = cnt_q + (PW + 1)'(do_push) - (PW + 1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

// ----- design/bsa_back.sv -----
module bsa_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  bsa_pkg::item_t item_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [6:0]     ascii_char_o,
  output logic [11:0]    pixel_x_o,
  output logic [11:0]    pixel_y_o,
  output logic           last_pixel_o,
  output logic [1:0]     status_o
);

  logic [14:0] scaled;
  logic [14:0] quot;
  logic [6:0]  idx;
  logic [6:0]  char_d, char_q;
  logic        valid_q;
  bsa_pkg::item_t item_q;

  // ceil(23*sum/255): the division by 255 is (v + 1 + (v >> 8)) >> 8, exact for v < 65535.
  assign scaled = 15'd23 * 15'(item_i.sum) + 15'd254;
  assign quot   = 15'((16'(scaled) + 16'd1 + 16'(scaled >> 8)) >> 8);
  assign idx    = (quot > 15'(bsa_pkg::RampMaxIdx)) ? bsa_pkg::RampMaxIdx : quot[6:0];
  assign char_d = (item_i.status == bsa_pkg::StPixel) ? bsa_pkg::RampChars[idx] : 7'd0;

  assign pop_o = !empty_i && (!valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= item_i;
      char_q <= char_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign ascii_char_o = char_q;
  assign pixel_x_o    = item_q.x;
  assign pixel_y_o    = item_q.y;
  assign last_pixel_o = item_q.last;
  assign status_o     = item_q.status;

endmodule

// ----- design/bmp_stream_to_ascii_chars.sv -----
// Converts a 24-bit bitmap file, fed one byte per item, into one brightness-ramp
// character per pixel. The parser takes a byte in every cycle while its four-entry
// queue has room; a pixel result follows every third pixel byte, and a bad signature
// or an oversize header gives a single error result. The character mapper empties
// the queue into the output register one item per cycle while the output is not
// stalled, so a result passes through the queue and then the output register.
module bmp_stream_to_ascii_chars #(
  parameter int unsigned MAX_WIDTH = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        file_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  ascii_char_o,
  output logic [11:0] pixel_x_o,
  output logic [11:0] pixel_y_o,
  output logic        last_pixel_o,
  output logic [1:0]  status_o
);

  logic           accept;
  logic           push;
  logic           full;
  logic           empty;
  logic           pop;
  bsa_pkg::item_t push_item;
  bsa_pkg::item_t head_item;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  bsa_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .file_start_i(file_start_i),
    .push_o      (push),
    .item_o      (push_item)
  );

  bsa_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_item_i(push_item),
    .full_o     (full),
    .pop_i      (pop),
    .pop_item_o (head_item),
    .empty_o    (empty)
  );

  bsa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .item_i      (head_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ascii_char_o(ascii_char_o),
    .pixel_x_o   (pixel_x_o),
    .pixel_y_o   (pixel_y_o),
    .last_pixel_o(last_pixel_o),
    .status_o    (status_o)
  );

endmodule
